FILE: sv/frs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Fresnel glass sampler.
// Depends on nothing; imported by the sampler core.
package frs_pkg;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [13:0] IOR_ONE = 14'd4096;
	localparam logic signed [17:0] S_ONE = 18'sd65536;
	localparam logic signed [17:0] S_NEG_ONE = -18'sd65536;
	// s2 * eta^2 above this means total internal reflection (2^56)
	localparam logic [60:0] TIR_LIMIT = 61'd72057594037927936;

	// Reset values of the configuration registers
	localparam logic [13:0] IOR_RESET = 14'd6144;
	localparam logic [16:0] REFL_RESET = 17'h10000;

	// Configuration register indexes
	localparam logic [2:0] REG_IOR = 3'd0;
	localparam logic [2:0] REG_RED = 3'd1;
	localparam logic [2:0] REG_GREEN = 3'd2;
	localparam logic [2:0] REG_BLUE = 3'd3;

	// Divider and root pipeline shapes
	localparam int D1_DW = 28;
	localparam int D1_QW = 33;
	localparam int D2_DW = 31;
	localparam int D2_QW = 17;
	localparam int D2_LANES = 4;
	localparam int SQRT_STEPS = 17;

	// Lanes of the second divider
	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_X = 2;
	localparam int LANE_Y = 3;

	// Accept edge to done strobe, in cycles
	localparam int LATENCY = 3 + D1_QW + 1 + SQRT_STEPS + 2 + D2_QW + 3;

	typedef enum logic [1:0] {
		KIND_REFL = 2'd0,
		KIND_REFR = 2'd1,
		KIND_TIR  = 2'd2
	} event_kind_t;

	// Per-item context carried down the pipeline
	typedef struct packed {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic [15:0]        u;
		logic [16:0]        az;
		logic               enter;
	} ctx_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [60:0] prod;
	} d1_side_t;

	typedef struct packed {
		ctx_t ctx;
		logic tir;
	} sq_side_t;

	typedef struct packed {
		ctx_t        ctx;
		logic        tir;
		logic [16:0] ct;
		logic [16:0] lx;
		logic [16:0] ly;
		logic        both_zero;
	} d2_side_t;

endpackage

FILE: sv/fresnel_refract_sampler_core.sv
`timescale 1ns / 1ps
// Fresnel glass sampler core: Snell cosine, averaged Fresnel reflectance, event pick.
// Depends on frs_pkg and the pipelined divider frs_div.
//
// Usage:
//   Input channel: drive out_dir_x/y/z (Q1.16) and rand_fraction with start high;
//   an item is taken at every rising edge where start is high and busy is low.
//   busy stays low: a new item may enter every cycle.
//   Result channel: done is high for exactly one cycle with in_dir_x/y/z,
//   sample_pdf, weight_red/green/blue and event_kind; results come in input order.
//   Throughput is one item per cycle. The pipeline holds the 33-stage divider
//   for the entering cosine, the 17-stage square root and the 17-stage divider
//   bank for the Fresnel ratios and the entering x/y scale.
//   Configuration: write cfg_data to register cfg_index with cfg_wr_en high
//   (0 index of refraction Q2.12, 1..3 red/green/blue reflectance Q1.16);
//   indexes 4 and above are ignored. Write only while no item is in flight.
//   Reset drops all items in flight and restores the register defaults.
//   The receiver cannot stall; each result is shown once and then replaced.
module fresnel_refract_sampler_core
	import frs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic signed [17:0] out_dir_x,
	input  logic signed [17:0] out_dir_y,
	input  logic signed [17:0] out_dir_z,
	input  logic [15:0]        rand_fraction,
	output logic               done,
	output logic signed [17:0] in_dir_x,
	output logic signed [17:0] in_dir_y,
	output logic signed [17:0] in_dir_z,
	output logic [16:0]        sample_pdf,
	output logic [16:0]        weight_red,
	output logic [16:0]        weight_green,
	output logic [16:0]        weight_blue,
	output logic [1:0]         event_kind
);

	function automatic logic signed [17:0] sat_q16(input logic signed [17:0] v);
		logic signed [17:0] r;
		if (v > S_ONE) begin
			r = S_ONE;
		end else if (v < S_NEG_ONE) begin
			r = S_NEG_ONE;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// ---------------- configuration ----------------
	logic [13:0] ior_q;
	logic [16:0] red_q, green_q, blue_q;
	logic [27:0] ior_sq_q;
	logic [13:0] ior_eff;
	logic [16:0] red_sat, green_sat, blue_sat;

	always_comb begin
		ior_eff   = (ior_q < IOR_ONE) ? IOR_ONE : ior_q;
		red_sat   = (red_q > ONE_Q16) ? ONE_Q16 : red_q;
		green_sat = (green_q > ONE_Q16) ? ONE_Q16 : green_q;
		blue_sat  = (blue_q > ONE_Q16) ? ONE_Q16 : blue_q;
	end

	// Hold register writes; keep eta^2 registered for the first divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ior_q    <= IOR_RESET;
			red_q    <= REFL_RESET;
			green_q  <= REFL_RESET;
			blue_q   <= REFL_RESET;
			ior_sq_q <= 28'd37748736;
		end else begin
			ior_sq_q <= ior_eff * ior_eff;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_IOR:   ior_q   <= cfg_data[13:0];
					REG_RED:   red_q   <= cfg_data;
					REG_GREEN: green_q <= cfg_data;
					REG_BLUE:  blue_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// ---------------- S1: capture and saturate ----------------
	logic accept;
	logic vld_s1;
	ctx_t ctx_s1;
	ctx_t ctx_in;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		ctx_in.x     = sat_q16(out_dir_x);
		ctx_in.y     = sat_q16(out_dir_y);
		ctx_in.z     = sat_q16(out_dir_z);
		ctx_in.u     = rand_fraction;
		ctx_in.az    = ctx_in.z[17] ? 17'(-ctx_in.z) : ctx_in.z[16:0];
		ctx_in.enter = (ctx_in.z > 18'sd0);
	end

	// ---------------- S2: sine squared ----------------
	logic        vld_s2;
	ctx_t        ctx_s2;
	logic [32:0] s2_s2;
	logic [33:0] az_sq;

	assign az_sq = ctx_s1.az * ctx_s1.az;

	// ---------------- S3: leaving product ----------------
	logic        vld_s3;
	ctx_t        ctx_s3;
	logic [32:0] s2_s3;
	logic [60:0] prod_s3;
	logic [60:0] prod;

	assign prod = s2_s2 * ior_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1  <= ctx_in;
		ctx_s2  <= ctx_s1;
		s2_s2   <= ONE_Q32 - az_sq[32:0];
		ctx_s3  <= ctx_s2;
		s2_s3   <= s2_s2;
		prod_s3 <= prod;
	end

	// ---------------- divider 1: (s2 << 24) / eta^2 ----------------
	logic [D1_DW+D1_QW-1:0] d1_dividend [1];
	logic [D1_DW-1:0]       d1_divisor [1];
	logic [D1_QW-1:0]       d1_quo [1];
	d1_side_t               d1_side_in, d1_side;
	logic                   d1_vld;

	always_comb begin
		d1_dividend[0]  = {4'b0, s2_s3, 24'b0};
		d1_divisor[0]   = ior_sq_q;
		d1_side_in.ctx  = ctx_s3;
		d1_side_in.prod = prod_s3;
	end

	frs_div #(
		.LANES (1),
		.DW    (D1_DW),
		.QW    (D1_QW),
		.SW    ($bits(d1_side_t))
	) u_div_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.dividend  (d1_dividend),
		.divisor   (d1_divisor),
		.side_in   (d1_side_in),
		.out_valid (d1_vld),
		.quotient  (d1_quo),
		.side_out  (d1_side)
	);

	// ---------------- S4: cosine squared, TIR test ----------------
	logic        vld_s4;
	logic [32:0] ct2_s4;
	sq_side_t    side_s4;
	logic [32:0] ct2;
	logic        tir;

	always_comb begin
		tir = !d1_side.ctx.enter && (d1_side.prod > TIR_LIMIT);
		if (d1_side.ctx.enter) begin
			ct2 = ONE_Q32 - d1_quo[0];
		end else begin
			ct2 = ONE_Q32 - d1_side.prod[56:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		ct2_s4      <= ct2;
		side_s4.ctx <= d1_side.ctx;
		side_s4.tir <= tir;
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [SQRT_STEPS-1:0] sq_vld_s;
	logic [32:0]           sq_rem_s [SQRT_STEPS];
	logic [16:0]           sq_root_s [SQRT_STEPS];
	sq_side_t              sq_side_s [SQRT_STEPS];
	logic [32:0]           sq_rem_src [SQRT_STEPS];
	logic [16:0]           sq_root_src [SQRT_STEPS];
	logic [32:0]           sq_rem_nx [SQRT_STEPS];
	logic [16:0]           sq_root_nx [SQRT_STEPS];

	always_comb begin
		sq_rem_src[0]  = ct2_s4;
		sq_root_src[0] = '0;
		for (int j = 1; j < SQRT_STEPS; j++) begin
			sq_rem_src[j]  = sq_rem_s[j-1];
			sq_root_src[j] = sq_root_s[j-1];
		end
	end

	// Try the next root bit against the remainder
	always_comb begin : sqrt_step
		logic [34:0] term;
		logic [34:0] rem_w;
		int          bit_i;
		for (int j = 0; j < SQRT_STEPS; j++) begin
			bit_i = SQRT_STEPS - 1 - j;
			term  = (35'(sq_root_src[j]) << (bit_i + 1)) + (35'd1 << (2 * bit_i));
			rem_w = 35'(sq_rem_src[j]);
			if (rem_w >= term) begin
				sq_rem_nx[j]  = 33'(rem_w - term);
				sq_root_nx[j] = sq_root_src[j] | (17'd1 << bit_i);
			end else begin
				sq_rem_nx[j]  = sq_rem_src[j];
				sq_root_nx[j] = sq_root_src[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
		end else begin
			sq_vld_s <= {sq_vld_s[SQRT_STEPS-2:0], vld_s4};
		end
	end

	always_ff @(posedge clk) begin
		sq_side_s[0] <= side_s4;
		for (int j = 1; j < SQRT_STEPS; j++) begin
			sq_side_s[j] <= sq_side_s[j-1];
		end
		for (int j = 0; j < SQRT_STEPS; j++) begin
			sq_rem_s[j]  <= sq_rem_nx[j];
			sq_root_s[j] <= sq_root_nx[j];
		end
	end

	// ---------------- S5: Fresnel operands ----------------
	logic        vld_s5;
	sq_side_t    side_s5;
	logic [16:0] ct_s5;
	logic [28:0] pa_s5, qb_s5;
	logic [30:0] qa_s5, pb_s5;
	logic [30:0] mlx_s5, mly_s5;
	logic        zero_s5;
	logic [16:0] ct5, a5, b5, mx5, my5;
	sq_side_t    sq_out;

	always_comb begin
		sq_out = sq_side_s[SQRT_STEPS-1];
		ct5    = sq_root_s[SQRT_STEPS-1];
		a5     = sq_out.ctx.enter ? sq_out.ctx.az : ct5;
		b5     = sq_out.ctx.enter ? ct5 : sq_out.ctx.az;
		mx5    = sq_out.ctx.x[17] ? 17'(-sq_out.ctx.x) : sq_out.ctx.x[16:0];
		my5    = sq_out.ctx.y[17] ? 17'(-sq_out.ctx.y) : sq_out.ctx.y[16:0];
	end

	// ---------------- S6: ratio terms and divider loads ----------------
	logic                   vld_s6;
	logic [D2_DW+D2_QW-1:0] d2_dividend_s6 [D2_LANES];
	logic [D2_DW-1:0]       d2_divisor_s6 [D2_LANES];
	d2_side_t               d2_side_s6;
	logic [30:0]            num_a, den_a, num_b, den_b;
	logic [30:0]            pa_w, qb_w;
	logic [18:0]            lx_w, ly_w;
	logic [16:0]            mx6, my6;

	always_comb begin
		pa_w  = {2'b0, pa_s5};
		qb_w  = {2'b0, qb_s5};
		num_a = (pa_w > qa_s5) ? (pa_w - qa_s5) : (qa_s5 - pa_w);
		den_a = pa_w + qa_s5;
		num_b = (pb_s5 > qb_w) ? (pb_s5 - qb_w) : (qb_w - pb_s5);
		den_b = pb_s5 + qb_w;
		lx_w  = mlx_s5[30:12];
		ly_w  = mly_s5[30:12];
		mx6   = side_s5.ctx.x[17] ? 17'(-side_s5.ctx.x) : side_s5.ctx.x[16:0];
		my6   = side_s5.ctx.y[17] ? 17'(-side_s5.ctx.y) : side_s5.ctx.y[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s5 <= sq_vld_s[SQRT_STEPS-1];
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= sq_out;
		ct_s5   <= ct5;
		pa_s5   <= {a5, 12'b0};
		qa_s5   <= ior_eff * b5;
		pb_s5   <= ior_eff * a5;
		qb_s5   <= {b5, 12'b0};
		mlx_s5  <= mx5 * ior_eff;
		mly_s5  <= my5 * ior_eff;
		zero_s5 <= (a5 == 17'd0) && (b5 == 17'd0);

		d2_dividend_s6[LANE_A] <= {1'b0, num_a, 16'b0};
		d2_divisor_s6[LANE_A]  <= den_a;
		d2_dividend_s6[LANE_B] <= {1'b0, num_b, 16'b0};
		d2_divisor_s6[LANE_B]  <= den_b;
		d2_dividend_s6[LANE_X] <= {19'b0, mx6, 12'b0};
		d2_divisor_s6[LANE_X]  <= {17'b0, ior_eff};
		d2_dividend_s6[LANE_Y] <= {19'b0, my6, 12'b0};
		d2_divisor_s6[LANE_Y]  <= {17'b0, ior_eff};
		d2_side_s6.ctx       <= side_s5.ctx;
		d2_side_s6.tir       <= side_s5.tir;
		d2_side_s6.ct        <= ct_s5;
		d2_side_s6.lx        <= (lx_w > 19'(ONE_Q16)) ? ONE_Q16 : lx_w[16:0];
		d2_side_s6.ly        <= (ly_w > 19'(ONE_Q16)) ? ONE_Q16 : ly_w[16:0];
		d2_side_s6.both_zero <= zero_s5;
	end

	// ---------------- divider 2: Fresnel ratios and entering x/y scale ----------------
	logic [D2_QW-1:0] d2_quo [D2_LANES];
	d2_side_t         d2_side;
	logic             d2_vld;

	frs_div #(
		.LANES (D2_LANES),
		.DW    (D2_DW),
		.QW    (D2_QW),
		.SW    ($bits(d2_side_t))
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.dividend  (d2_dividend_s6),
		.divisor   (d2_divisor_s6),
		.side_in   (d2_side_s6),
		.out_valid (d2_vld),
		.quotient  (d2_quo),
		.side_out  (d2_side)
	);

	// ---------------- S7: square the ratios ----------------
	logic        vld_s7;
	d2_side_t    side_s7;
	logic [16:0] sqa_s7, sqb_s7, sx_s7, sy_s7;
	logic [33:0] sqa_full, sqb_full;

	assign sqa_full = d2_quo[LANE_A] * d2_quo[LANE_A];
	assign sqb_full = d2_quo[LANE_B] * d2_quo[LANE_B];

	// ---------------- S8: pick the event ----------------
	logic               vld_s8;
	logic signed [17:0] dx_s8, dy_s8, dz_s8;
	logic [16:0]        pdf_s8;
	event_kind_t        kind_s8;
	logic [17:0]        fr_sum;
	logic [16:0]        fr8;
	logic signed [17:0] dx8, dy8, dz8;
	logic signed [17:0] sxs, sys, lxs, lys, cts;
	logic [16:0]        pdf8;
	event_kind_t        kind8;

	always_comb begin
		fr_sum = {1'b0, sqa_s7} + {1'b0, sqb_s7};
		fr8    = side_s7.both_zero ? ONE_Q16 : fr_sum[17:1];
		sxs    = $signed({1'b0, sx_s7});
		sys    = $signed({1'b0, sy_s7});
		lxs    = $signed({1'b0, side_s7.lx});
		lys    = $signed({1'b0, side_s7.ly});
		cts    = $signed({1'b0, side_s7.ct});
		dx8    = -side_s7.ctx.x;
		dy8    = -side_s7.ctx.y;
		dz8    = side_s7.ctx.z;
		pdf8   = fr8;
		kind8  = KIND_REFL;
		priority if (side_s7.tir) begin
			pdf8  = ONE_Q16;
			kind8 = KIND_TIR;
		end else if ({1'b0, side_s7.ctx.u} < fr8) begin
			kind8 = KIND_REFL;
		end else begin
			pdf8  = ONE_Q16 - fr8;
			kind8 = KIND_REFR;
			priority if (side_s7.ctx.az == ONE_Q16) begin
				// normal incidence: straight through
				dx8 = '0;
				dy8 = '0;
				dz8 = -side_s7.ctx.z;
			end else if (side_s7.ctx.enter) begin
				dx8 = side_s7.ctx.x[17] ? sxs : -sxs;
				dy8 = side_s7.ctx.y[17] ? sys : -sys;
				dz8 = -cts;
			end else begin
				dx8 = side_s7.ctx.x[17] ? lxs : -lxs;
				dy8 = side_s7.ctx.y[17] ? lys : -lys;
				dz8 = cts;
			end
		end
	end

	// ---------------- S9: color weights and result registers ----------------
	logic               vld_s9;
	logic signed [17:0] dx_s9, dy_s9, dz_s9;
	logic [16:0]        pdf_s9, wr_s9, wg_s9, wb_s9;
	event_kind_t        kind_s9;
	logic [33:0]        wr_full, wg_full, wb_full;

	assign wr_full = pdf_s8 * red_sat;
	assign wg_full = pdf_s8 * green_sat;
	assign wb_full = pdf_s8 * blue_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s7 <= d2_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= d2_side;
		sqa_s7  <= sqa_full[32:16];
		sqb_s7  <= sqb_full[32:16];
		sx_s7   <= (d2_quo[LANE_X] > ONE_Q16) ? ONE_Q16 : d2_quo[LANE_X];
		sy_s7   <= (d2_quo[LANE_Y] > ONE_Q16) ? ONE_Q16 : d2_quo[LANE_Y];

		dx_s8   <= dx8;
		dy_s8   <= dy8;
		dz_s8   <= dz8;
		pdf_s8  <= pdf8;
		kind_s8 <= kind8;

		dx_s9   <= dx_s8;
		dy_s9   <= dy_s8;
		dz_s9   <= dz_s8;
		pdf_s9  <= pdf_s8;
		kind_s9 <= kind_s8;
		wr_s9   <= wr_full[32:16];
		wg_s9   <= wg_full[32:16];
		wb_s9   <= wb_full[32:16];
	end

	assign done         = vld_s9;
	assign in_dir_x     = dx_s9;
	assign in_dir_y     = dy_s9;
	assign in_dir_z     = dz_s9;
	assign sample_pdf   = pdf_s9;
	assign weight_red   = wr_s9;
	assign weight_green = wg_s9;
	assign weight_blue  = wb_s9;
	assign event_kind   = kind_s9;

`ifndef NO_ASSERTIONS
	// Every accepted item comes out after the fixed pipeline depth
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item did not complete on time");

	// No result without an item accepted at the matching edge
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a matching accepted item");

	// Total internal reflection is certain
	a_tir_pdf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (event_kind == KIND_TIR)) |-> (sample_pdf == ONE_Q16))
		else $error("total internal reflection with pdf below one");

	// A Fresnel reflection is only drawn with a nonzero reflectance
	a_refl_pdf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (event_kind == KIND_REFL)) |-> (sample_pdf != 17'd0))
		else $error("reflection chosen with zero probability");
`endif

endmodule

FILE: sv/frs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, several lanes in step.
// Carries a valid bit and a sideband word alongside; depends on no package.
module frs_div #(
	parameter int LANES = 1,
	parameter int DW = 28,
	parameter int QW = 33,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DW+QW-1:0]  dividend [LANES],
	input  logic [DW-1:0]     divisor [LANES],
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic [QW-1:0]     quotient [LANES],
	output logic [SW-1:0]     side_out
);

	logic [QW-1:0] vld_s;
	logic [DW-1:0] rem_s [QW][LANES];
	logic [QW-1:0] quo_s [QW][LANES];
	logic [DW-1:0] dvs_s [QW][LANES];
	logic [SW-1:0] side_s [QW];

	logic [DW-1:0] rem_src [QW][LANES];
	logic [QW-1:0] quo_src [QW][LANES];
	logic [DW-1:0] dvs_src [QW][LANES];
	logic [DW-1:0] rem_nx [QW][LANES];
	logic [QW-1:0] quo_nx [QW][LANES];

	// Feed each stage from the ports or from the stage above
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_src[0][l] = dividend[l][DW+QW-1:QW];
			quo_src[0][l] = dividend[l][QW-1:0];
			dvs_src[0][l] = divisor[l];
		end
		for (int k = 1; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_src[k][l] = rem_s[k-1][l];
				quo_src[k][l] = quo_s[k-1][l];
				dvs_src[k][l] = dvs_s[k-1][l];
			end
		end
	end

	// Shift in one dividend bit, subtract the divisor where it fits
	always_comb begin : div_step
		logic [DW:0] trial;
		logic        take;
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_src[k][l], quo_src[k][l][QW-1]};
				take = (trial >= {1'b0, dvs_src[k][l]});
				if (take) begin
					rem_nx[k][l] = DW'(trial - {1'b0, dvs_src[k][l]});
				end else begin
					rem_nx[k][l] = trial[DW-1:0];
				end
				quo_nx[k][l] = {quo_src[k][l][QW-2:0], take};
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-2:0], in_valid};
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < QW; k++) begin
			side_s[k] <= side_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[k][l] <= rem_nx[k][l];
				quo_s[k][l] <= quo_nx[k][l];
				dvs_s[k][l] <= dvs_src[k][l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quotient[l] = quo_s[QW-1][l];
		end
	end

	assign out_valid = vld_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Fresnel glass sampler core.
// Depends on frs_pkg and fresnel_refract_sampler_core; drives directed and random items.
module testbench;
	import frs_pkg::*;

	typedef struct packed {
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic [16:0]        pdf;
		logic [16:0]        wr;
		logic [16:0]        wg;
		logic [16:0]        wb;
		event_kind_t        kind;
	} sample_t;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic [15:0]        u;
		bit                 typed;
		sample_t            want;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [16:0]        cfg_data = '0;
	logic signed [17:0] out_dir_x = '0;
	logic signed [17:0] out_dir_y = '0;
	logic signed [17:0] out_dir_z = '0;
	logic [15:0]        rand_fraction = '0;
	logic               busy;
	logic               done;
	logic signed [17:0] in_dir_x;
	logic signed [17:0] in_dir_y;
	logic signed [17:0] in_dir_z;
	logic [16:0]        sample_pdf;
	logic [16:0]        weight_red;
	logic [16:0]        weight_green;
	logic [16:0]        weight_blue;
	logic [1:0]         event_kind;

	// Local copy of the configuration registers
	logic [13:0] ior_reg = IOR_RESET;
	logic [16:0] red_reg = REFL_RESET;
	logic [16:0] green_reg = REFL_RESET;
	logic [16:0] blue_reg = REFL_RESET;

	sample_t expected_samples[$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;

	// Directed items at the reset configuration
	dir_row_t dir_rows[] = '{
		'{18'sd0, 18'sd0, 18'sd65536, 16'd0, 1'b1,
			'{18'sd0, 18'sd0, 18'sd65536, 17'd2621, 17'd2621, 17'd2621, 17'd2621, KIND_REFL}},
		'{18'sd0, 18'sd0, 18'sd65536, 16'd65535, 1'b1,
			'{18'sd0, 18'sd0, -18'sd65536, 17'd62915, 17'd62915, 17'd62915, 17'd62915,
			KIND_REFR}},
		'{18'sd65536, 18'sd0, 18'sd0, 16'd0, 1'b1,
			'{-18'sd65536, 18'sd0, 18'sd0, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
			KIND_TIR}},
		'{18'sd0, 18'sd0, -18'sd65536, 16'd0, 1'b1,
			'{18'sd0, 18'sd0, -18'sd65536, 17'd2621, 17'd2621, 17'd2621, 17'd2621, KIND_REFL}},
		'{18'sd0, 18'sd0, -18'sd65536, 16'd65535, 1'b1,
			'{18'sd0, 18'sd0, 18'sd65536, 17'd62915, 17'd62915, 17'd62915, 17'd62915,
			KIND_REFR}},
		'{-18'sd131072, 18'sd131071, 18'sd131071, 16'd65535, 1'b0, '0},
		'{18'sd131071, -18'sd131072, -18'sd131072, 16'd65535, 1'b0, '0},
		'{18'sd65536, -18'sd65536, 18'sd1, 16'd65535, 1'b0, '0},
		'{18'sd65536, 18'sd0, 18'sd1, 16'd0, 1'b0, '0},
		'{-18'sd65536, 18'sd0, -18'sd1, 16'd30000, 1'b0, '0},
		'{18'sd40000, -18'sd40000, 18'sd30000, 16'd65535, 1'b0, '0},
		'{18'sd40000, -18'sd40000, 18'sd30000, 16'd0, 1'b0, '0},
		'{18'sd20000, 18'sd10000, -18'sd60000, 16'd65535, 1'b0, '0},
		'{18'sd20000, 18'sd10000, -18'sd60000, 16'd0, 1'b0, '0},
		'{-18'sd30000, 18'sd25000, -18'sd50000, 16'd40000, 1'b0, '0},
		'{18'sd1, -18'sd1, 18'sd65535, 16'd32768, 1'b0, '0},
		'{-18'sd1, 18'sd1, -18'sd65535, 16'd65535, 1'b0, '0},
		'{18'sd50000, 18'sd40000, -18'sd30000, 16'd1, 1'b0, '0}
	};

	fresnel_refract_sampler_core u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp_q16(longint v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic longint unsigned clamp_u16(longint unsigned v);
		return v > 65536 ? 65536 : v;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// Square of |p - q| / (p + q) as a Q1.16 fraction, with floors
	function automatic longint unsigned ratio_squared(longint unsigned p, longint unsigned q);
		longint unsigned num, den, r;
		num = p > q ? p - q : q - p;
		den = p + q;
		if (den == 0) return 65536;
		r = (num << 16) / den;
		return (r * r) >> 16;
	endfunction

	function automatic longint unsigned fresnel_avg(longint unsigned a, longint unsigned b,
			longint unsigned ior);
		if (a == 0 && b == 0) return 65536;
		return (ratio_squared(a << 12, ior * b) + ratio_squared(ior * a, b << 12)) >> 1;
	endfunction

	// Scale the magnitude, truncate toward zero, keep the sign
	function automatic longint scale_lateral(longint v, longint unsigned mul,
			longint unsigned dv);
		longint unsigned m, r;
		m = v < 0 ? -v : v;
		r = clamp_u16((m * mul) / dv);
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic sample_t predict_sample(logic signed [17:0] rx, logic signed [17:0] ry,
			logic signed [17:0] rz, logic [15:0] u);
		sample_t s;
		longint x, y, z, ox, oy, oz;
		longint unsigned ior, ior2, az, s2, fr, pdf, ct;
		event_kind_t kind;
		x = clamp_q16(longint'(rx));
		y = clamp_q16(longint'(ry));
		z = clamp_q16(longint'(rz));
		ior = ior_reg < 14'd4096 ? 4096 : ior_reg;
		ior2 = ior * ior;
		az = z < 0 ? -z : z;
		s2 = (64'd1 << 32) - az * az;
		if (z > 0) begin
			// Enter the glass
			ct = floor_root((64'd1 << 32) - ((s2 << 24) / ior2));
			fr = fresnel_avg(az, ct, ior);
			if (longint'(u) < fr) begin
				ox = -x; oy = -y; oz = z; pdf = fr; kind = KIND_REFL;
			end else begin
				if (az == 65536) begin
					ox = 0; oy = 0; oz = -z;
				end else begin
					ox = -scale_lateral(x, 4096, ior);
					oy = -scale_lateral(y, 4096, ior);
					oz = -longint'(ct);
				end
				pdf = 65536 - fr; kind = KIND_REFR;
			end
		end else if (s2 * ior2 > (64'd1 << 56)) begin
			ox = -x; oy = -y; oz = z; pdf = 65536; kind = KIND_TIR;
		end else begin
			// Leave the glass
			ct = floor_root((64'd1 << 32) - ((s2 * ior2) >> 24));
			fr = fresnel_avg(ct, az, ior);
			if (longint'(u) < fr) begin
				ox = -x; oy = -y; oz = z; pdf = fr; kind = KIND_REFL;
			end else begin
				if (az == 65536) begin
					ox = 0; oy = 0; oz = -z;
				end else begin
					ox = -scale_lateral(x, ior, 4096);
					oy = -scale_lateral(y, ior, 4096);
					oz = longint'(ct);
				end
				pdf = 65536 - fr; kind = KIND_REFR;
			end
		end
		pdf = clamp_u16(pdf);
		s.dx = 18'(clamp_q16(ox));
		s.dy = 18'(clamp_q16(oy));
		s.dz = 18'(clamp_q16(oz));
		s.pdf = 17'(pdf);
		s.wr = 17'(clamp_u16((pdf * clamp_u16(red_reg)) >> 16));
		s.wg = 17'(clamp_u16((pdf * clamp_u16(green_reg)) >> 16));
		s.wb = 17'(clamp_u16((pdf * clamp_u16(blue_reg)) >> 16));
		s.kind = kind;
		return s;
	endfunction

	// Write one register while the block is idle and track it locally
	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_IOR:   ior_reg = val[13:0];
			REG_RED:   red_reg = val;
			REG_GREEN: green_reg = val;
			REG_BLUE:  blue_reg = val;
			default: ;
		endcase
		// Let the enable drop before the next write
		@(posedge clk);
	endtask

	// Offer one item, hold until taken, then idle for the requested gap
	task automatic send_item(logic signed [17:0] x, logic signed [17:0] y,
			logic signed [17:0] z, logic [15:0] u, bit typed, sample_t want, int gap);
		out_dir_x <= x;
		out_dir_y <= y;
		out_dir_z <= z;
		rand_fraction <= u;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_samples.push_back(typed ? want : predict_sample(x, y, z, u));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic signed [17:0] pick_component();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 18'($urandom());
		if (r < 4) return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
		return 18'($urandom_range(0, 131072) - 65536);
	endfunction

	// Random items; quiet runs back-to-back with no idle gaps
	task automatic send_random(int count, bit quiet);
		logic signed [17:0] x, y, z;
		for (int i = 0; i < count; i++) begin
			x = pick_component();
			y = pick_component();
			z = pick_component();
			send_item(x, y, z, 16'($urandom()), 1'b0, '0, quiet ? 0 : pick_gap());
		end
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && done) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: result with no item pending", $time);
				mismatch_count++;
			end else begin
				want = expected_samples.pop_front();
				if (in_dir_x !== want.dx) begin
					$display("%0t: in_dir_x exp %0d got %0d", $time, want.dx, in_dir_x);
					mismatch_count++;
				end
				if (in_dir_y !== want.dy) begin
					$display("%0t: in_dir_y exp %0d got %0d", $time, want.dy, in_dir_y);
					mismatch_count++;
				end
				if (in_dir_z !== want.dz) begin
					$display("%0t: in_dir_z exp %0d got %0d", $time, want.dz, in_dir_z);
					mismatch_count++;
				end
				if (sample_pdf !== want.pdf) begin
					$display("%0t: sample_pdf exp %0d got %0d", $time, want.pdf, sample_pdf);
					mismatch_count++;
				end
				if (weight_red !== want.wr) begin
					$display("%0t: weight_red exp %0d got %0d", $time, want.wr, weight_red);
					mismatch_count++;
				end
				if (weight_green !== want.wg) begin
					$display("%0t: weight_green exp %0d got %0d", $time, want.wg, weight_green);
					mismatch_count++;
				end
				if (weight_blue !== want.wb) begin
					$display("%0t: weight_blue exp %0d got %0d", $time, want.wb, weight_blue);
					mismatch_count++;
				end
				if (event_kind !== want.kind) begin
					$display("%0t: event_kind exp %0d got %0d", $time, want.kind, event_kind);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset values
		foreach (dir_rows[i])
			send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].u,
				dir_rows[i].typed, dir_rows[i].want, i % 3);
		send_random(80, 1'b0);
		drain_results();

		// Index of one, zero red, half blue; grazing exit gives full reflectance
		write_reg(REG_IOR, 17'd4096);
		write_reg(REG_RED, 17'd0);
		write_reg(REG_BLUE, 17'd32768);
		send_item(18'sd65536, 18'sd0, 18'sd0, 16'd65535, 1'b0, '0, 0);
		send_item(18'sd0, -18'sd65536, 18'sd0, 16'd0, 1'b0, '0, 0);
		send_item(18'sd30000, 18'sd20000, 18'sd40000, 16'd100, 1'b0, '0, 1);
		send_random(100, 1'b0);
		drain_results();

		// Densest glass; hold off once mid-phase until all results are in
		write_reg(REG_IOR, 17'd16383);
		write_reg(REG_RED, 17'd65536);
		write_reg(REG_GREEN, 17'd1);
		write_reg(REG_BLUE, 17'd65535);
		send_random(50, 1'b0);
		drain_results();
		send_random(50, 1'b0);
		drain_results();

		// Index below one, reflectance above one, ignored indexes
		write_reg(REG_IOR, 17'd100);
		write_reg(REG_RED, 17'd131071);
		write_reg(REG_GREEN, 17'd70000);
		write_reg(REG_BLUE, 17'd0);
		write_reg(3'd4, 17'd1);
		write_reg(3'd7, 17'h1FFFF);
		send_random(100, 1'b0);
		drain_results();

		// Wide register data, then back-to-back items
		write_reg(REG_IOR, 17'h1_2000);
		write_reg(3'd5, 17'd12345);
		send_random(60, 1'b1);
		send_random(50, 1'b0);
		drain_results();

		// Random settings
		for (int p = 0; p < 2; p++) begin
			write_reg(REG_IOR, 17'($urandom_range(0, 16383)));
			write_reg(REG_RED, 17'($urandom_range(0, 131071)));
			write_reg(REG_GREEN, 17'($urandom_range(0, 65536)));
			write_reg(REG_BLUE, 17'($urandom_range(0, 65536)));
			send_random(60, 1'b0);
			drain_results();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
